### rtl/rdi_pkg.sv
package rdi_pkg;
    localparam int MAX_DIM_DEF = 16;
    localparam int DW = 32;
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    typedef enum logic [1:0] {
        OP_GCD,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_alu_rsp;
endpackage

### rtl/rational_diagonal_inverse.sv
// Flow: the first nonzero entry of a matrix, a zero entry, one whose magnitude
// overflows, one after an overflow or one past MAX_DIM is taken without a stall;
// any other entry then stalls for a gcd of remainder steps, a division and an lcm check.
// The last entry adds a gcd with the denominator and, unless it is zero, two divisions,
// then per result a division (none on an error code), states S_RQ and S_RM, then the offer.
// Throughput: one item at a time; not ready while the sequencer is busy.
// Reset: synchronous active low; counters, lcm, flags cleared; store not.
module rational_diagonal_inverse #(
    parameter int MAX_DIM = rdi_pkg::MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // diag_entry[31:0], denominator[62:32]
    input  logic        i_s_tlast,  // last_entry
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,  // inverse_entry[31:0], entry_index[35:32],
                                    // inverse_denominator[66:36], error_code[68:67]
    output logic        o_m_tlast   // last_result
);
    import rdi_pkg::*;

    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    typedef enum logic [3:0] {
        S_IN, S_LG, S_LD, S_LM, S_FG, S_FD1, S_FD2, S_RD, S_RQ, S_RM, S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_store [MAX_DIM];
    logic [CW-1:0] r_cnt, r_k;
    logic [31:0] r_lcm, r_m, r_tmp, r_d1, r_invden, r_ek;
    logic [30:0] r_den;
    logic [1:0]  r_err;
    logic        r_last;
    logic [63:0] r_prod;
    t_alu_req    n_req;
    t_alu_rsp    w_rsp;
    logic [31:0] w_e, w_mag, w_ekm, w_pval;
    logic [1:0]  w_code;
    logic        w_neg, w_fold, w_povf;

    rdi_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(n_req), .o_rsp(w_rsp));

    assign w_e    = i_s_tdata[31:0];
    assign w_mag  = w_e[31] ? (32'd0 - w_e) : w_e;
    assign w_neg  = r_ek[31];
    assign w_ekm  = w_neg ? (32'd0 - r_ek) : r_ek;
    assign w_code = r_err[0] ? ERR_ZERO : (r_err[1] ? ERR_OVF : ERR_NONE);
    assign w_fold = (r_cnt < CW'(MAX_DIM)) && (w_mag != '0) && !r_err[1] &&
                    !w_mag[31] && (r_lcm != '0);
    assign w_povf = w_neg ? (r_prod > 64'h8000_0000) : (r_prod > 64'h7FFF_FFFF);
    assign w_pval = w_neg ? (32'd0 - r_prod[31:0]) : r_prod[31:0];
    assign o_s_tready = (r_state == S_IN);

    always_comb begin
        n_req = '0;
        unique case (r_state)
            S_LG:  n_req = '{1'b1, OP_GCD, r_lcm, r_m};
            S_LD:  n_req = '{1'b1, OP_DIV, r_lcm, r_tmp};
            S_FG:  n_req = '{1'b1, OP_GCD, r_lcm, {1'b0, r_den}};
            S_FD1: n_req = '{1'b1, OP_DIV, {1'b0, r_den}, r_tmp};
            S_FD2: n_req = '{1'b1, OP_DIV, r_lcm, r_tmp};
            S_RD:  n_req = '{(w_code == ERR_NONE), OP_DIV, r_lcm, w_ekm};
            default: n_req = '0;
        endcase
        n_req.start = n_req.start & ~w_rsp.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_cnt <= '0;
            r_lcm <= '0;
            r_den <= '0;
            r_err <= '0;
            r_k <= '0;
            o_m_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IN: if (i_s_tvalid) begin
                    r_last <= i_s_tlast;
                    r_state <= w_fold ? S_LG : (i_s_tlast ? S_FG : S_IN);
                    if (r_cnt == '0) r_den <= i_s_tdata[62:32];
                    if (r_cnt < CW'(MAX_DIM)) begin
                        r_store[r_cnt[AW-1:0]] <= w_e;
                        r_cnt <= r_cnt + 1'b1;
                        if (w_mag == '0) r_err[0] <= 1'b1;
                        else if (!r_err[1]) begin
                            if (w_mag[31]) r_err[1] <= 1'b1;
                            else if (r_lcm == '0) r_lcm <= w_mag;
                            else r_m <= w_mag;
                        end
                    end else r_err[1] <= 1'b1;
                end
                S_LG: if (w_rsp.done) begin r_tmp <= w_rsp.res; r_state <= S_LD; end
                S_LD: if (w_rsp.done) begin
                    r_prod <= 64'(w_rsp.res) * 64'(r_m);
                    r_state <= S_LM;
                end
                S_LM: begin
                    if (r_prod > 64'h7FFF_FFFF) r_err[1] <= 1'b1;
                    else r_lcm <= r_prod[31:0];
                    r_state <= r_last ? S_FG : S_IN;
                end
                S_FG: if (w_rsp.done) begin
                    r_tmp <= w_rsp.res;
                    r_state <= (w_rsp.res == '0) ? S_RD : S_FD1;
                    if (w_rsp.res == '0) begin r_d1 <= '0; r_invden <= '0; end
                    r_k <= '0;
                    r_ek <= r_store[0];
                end
                S_FD1: if (w_rsp.done) begin r_d1 <= w_rsp.res; r_state <= S_FD2; end
                S_FD2: if (w_rsp.done) begin r_invden <= w_rsp.res; r_state <= S_RD; end
                S_RD: if (w_code != ERR_NONE) begin
                    o_m_tdata <= {3'b000, w_code, 31'd0, 4'(r_k), 32'd0};
                    o_m_tlast <= (r_k == r_cnt - 1'b1);
                    o_m_tvalid <= 1'b1;
                    r_state <= S_OUT;
                end else if (w_rsp.done) begin
                    r_tmp <= (w_ekm == '0) ? '0 : w_rsp.res;
                    r_state <= S_RQ;
                end
                S_RQ: begin
                    r_prod <= 64'(r_d1) * 64'(r_tmp);
                    r_state <= S_RM;
                end
                S_RM: begin
                    o_m_tdata <= {3'b000, (w_povf ? ERR_OVF : ERR_NONE), r_invden[30:0],
                                  4'(r_k), (w_povf ? 32'd0 : w_pval)};
                    o_m_tlast <= (r_k == r_cnt - 1'b1);
                    o_m_tvalid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_m_tready) begin
                    o_m_tvalid <= 1'b0;
                    if (r_k == r_cnt - 1'b1) begin
                        r_cnt <= '0; r_lcm <= '0; r_den <= '0; r_err <= '0;
                        r_state <= S_IN;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_ek <= r_store[AW'(r_k + 1'b1)];
                        r_state <= S_RD;
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready) else $error("accept while emitting");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_DIM)) else $error("count overflow");
endmodule

### rtl/rdi_alu.sv
module rdi_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdi_pkg::t_alu_req i_req,
    output rdi_pkg::t_alu_rsp o_rsp
);
    import rdi_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} t_state;

    t_state      r_state;
    t_op         r_op;
    logic [31:0] r_a, r_b, r_q, r_rem;
    logic [5:0]  r_cnt;
    logic [32:0] n_trial;
    logic [31:0] n_rem;

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_trial = {r_rem, r_a[31]} - {1'b0, r_b};
        n_rem   = n_trial[32] ? {r_rem[30:0], r_a[31]} : n_trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_op <= i_req.op;
                        r_a  <= i_req.a;
                        r_b  <= i_req.b;
                        r_rem <= '0;
                        r_cnt <= '0;
                        if (i_req.b == '0) begin
                            r_q     <= (i_req.op == OP_GCD) ? i_req.a : '0;
                            r_state <= S_DONE;
                        end else begin
                            r_q     <= i_req.a;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == 6'd31 && r_op == OP_GCD && n_rem != '0) begin
                        r_a   <= r_b;
                        r_b   <= n_rem;
                        r_rem <= '0;
                        r_cnt <= '0;
                    end else begin
                        r_rem <= n_rem;
                        r_a   <= {r_a[30:0], ~n_trial[32]};
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd31) begin
                            r_q     <= (r_op == OP_DIV) ? {r_a[30:0], ~n_trial[32]} : r_b;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.res  = r_q;
endmodule

### bench/rational_diagonal_inverse_test.sv
`timescale 1ns / 100ps

module rational_diagonal_inverse_test;
    import rdi_pkg::*;

    localparam int DIM = 16;
    localparam longint POS_MAX = 64'd2147483647;
    localparam int WATCHDOG = 200000;

    typedef struct {
        logic [31:0] entry;
        logic [30:0] den;
        logic        last;
    } t_in_item;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic [30:0] inv_den;
        logic [1:0]  code;
        logic        last;
    } t_out_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic        o_m_tlast;

    rational_diagonal_inverse u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),  // diag_entry[31:0], denominator[62:32]
        .i_s_tlast  (i_s_tlast),  // last_entry
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),  // inverse_entry, entry_index, inverse_denominator, error_code
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item expected_inverse[$];

    logic [31:0] mat_entries[DIM];
    int          mat_count = 0;
    longint      mat_lcm = 0;
    longint      mat_den = 0;
    logic [1:0]  mat_flags = '0;

    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    int  quiet_cycles = 0;
    bit  timed_out = 1'b0;

    function automatic longint gcd64(longint a, longint b);
        longint t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic longint mag32(logic [31:0] v);
        if (v[31])
            return 64'h1_0000_0000 - longint'({32'd0, v});
        return longint'({32'd0, v});
    endfunction

    // fold one accepted item into the running matrix and queue results on last
    task automatic fold_entry(t_in_item it);
        longint m, nl, g, d1, invden, q, p;
        logic [1:0] code, c;
        t_out_item r;
        if (mat_count == 0)
            mat_den = longint'({33'd0, it.den});
        if (mat_count < DIM) begin
            m = mag32(it.entry);
            mat_entries[mat_count] = it.entry;
            mat_count++;
            if (m == 0) begin
                mat_flags[0] = 1'b1;
            end else if (!mat_flags[1]) begin
                nl = (mat_lcm == 0) ? m : (mat_lcm / gcd64(mat_lcm, m)) * m;
                if (nl > POS_MAX)
                    mat_flags[1] = 1'b1;
                else
                    mat_lcm = nl;
            end
        end else begin
            mat_flags[1] = 1'b1;
        end
        if (!it.last)
            return;
        g = gcd64(mat_lcm, mat_den);
        d1 = (g != 0) ? mat_den / g : 0;
        invden = (g != 0) ? mat_lcm / g : 0;
        code = mat_flags[0] ? ERR_ZERO : (mat_flags[1] ? ERR_OVF : ERR_NONE);
        for (int k = 0; k < mat_count; k++) begin
            r.value = '0;
            r.inv_den = '0;
            c = code;
            if (c == ERR_NONE) begin
                m = mag32(mat_entries[k]);
                q = (m != 0) ? mat_lcm / m : 0;
                p = d1 * q;
                r.inv_den = invden[30:0];
                if ((!mat_entries[k][31] && p > POS_MAX) ||
                    (mat_entries[k][31] && p > POS_MAX + 1))
                    c = ERR_OVF;
                else
                    r.value = mat_entries[k][31] ? 32'(-p) : p[31:0];
            end
            r.index = k[3:0];
            r.code = c;
            r.last = (k == mat_count - 1);
            expected_inverse.push_back(r);
        end
        mat_count = 0;
        mat_lcm = 0;
        mat_den = 0;
        mat_flags = '0;
    endtask

    task automatic push_item(logic [31:0] e, logic [30:0] d, logic l);
        t_in_item it;
        it.entry = e;
        it.den = d;
        it.last = l;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return 32'(int'($urandom_range(0, 12)) - 6);
            1: return $urandom();
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'(-int'($urandom_range(1, 60)));
            default: return 32'($urandom_range(1, 60));
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(0, 7))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom());
            default: return 31'($urandom_range(1, 720));
        endcase
    endfunction

    task automatic push_matrix(int n);
        for (int k = 0; k < n; k++)
            push_item(rand_entry(), rand_den(), k == n - 1);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_inverse.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                fold_entry(pending_items.pop_front());
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_items.size() != 0 &&
                    !hold_off && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {1'b0, pending_items[0].den, pending_items[0].entry};
                    i_s_tlast <= pending_items[0].last;
                end else begin
                    i_s_tvalid <= 1'b0;
                    i_s_tdata <= {$urandom(), $urandom()};
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_inverse.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h last %b", o_m_tdata, o_m_tlast);
                end else begin
                    exp_r = expected_inverse.pop_front();
                    if (o_m_tdata[31:0] !== exp_r.value ||
                        o_m_tdata[35:32] !== exp_r.index ||
                        o_m_tdata[66:36] !== exp_r.inv_den ||
                        o_m_tdata[68:67] !== exp_r.code || o_m_tlast !== exp_r.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp val %h idx %0d den %h code %0d last %b,",
                                      " got val %h idx %0d den %h code %0d last %b"},
                                exp_r.value, exp_r.index, exp_r.inv_den, exp_r.code,
                                exp_r.last, o_m_tdata[31:0], o_m_tdata[35:32],
                                o_m_tdata[66:36], o_m_tdata[68:67], o_m_tlast);
                    end
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
                timed_out <= 1'b1;
        end
    end

    initial begin
        int sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_item(32'd1, 31'd1, 1'b1);
        push_item(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        push_item(32'hFFFF_FFFF, 31'd5, 1'b1);
        push_item(32'h8000_0000, 31'd3, 1'b1);
        push_item(32'd4, 31'd6, 1'b0);
        push_item(32'd0, 31'd1, 1'b0);
        push_item(32'd6, 31'd1, 1'b1);
        push_item(32'd3, 31'd0, 1'b0);
        push_item(32'hFFFF_FFFA, 31'd0, 1'b1);
        push_item(32'd65536, 31'd2147483646, 1'b0);
        push_item(32'd65535, 31'd1, 1'b1);
        push_item(32'hFFFF_FFFE, 31'h7FFF_FFFF, 1'b0);
        push_item(32'd3, 31'd1, 1'b1);
        for (int k = 0; k < 18; k++)
            push_item(32'(k % 5 + 1), 31'd7, k == 17);
        drain();

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 60 : (ph == 3) ? 25 : 0;
            recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 25 : 0;
            while (sent < (ph + 1) * 112) begin
                int n;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 17) : $urandom_range(1, 6);
                push_matrix(n);
                sent += n;
            end
            while (pending_items.size() != 0)
                @(posedge i_clk);
            hold_off = 1'b1;
            while (expected_inverse.size() != 0)
                @(posedge i_clk);
            hold_off = 1'b0;
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (mismatches == 0 && expected_inverse.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (timed_out) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end
endmodule

### rational_diagonal_inverse.f
rtl/rdi_pkg.sv
rtl/rdi_alu.sv
rtl/rational_diagonal_inverse.sv
bench/rational_diagonal_inverse_test.sv
